// ===== sv/sparse_row_assembly_table_core_defines.svh =====
// Assertion macros shared by the sparse row table RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef SPARSE_ROW_ASSEMBLY_TABLE_CORE_DEFINES_SVH
`define SPARSE_ROW_ASSEMBLY_TABLE_CORE_DEFINES_SVH

// Same-cycle implication.
`define SRAT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sparse row table check failed");

// Next-cycle implication.
`define SRAT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sparse row table check failed");

`endif

// ===== sv/srat_pkg.sv =====
package srat_pkg;

	localparam int MAX_ROWS   = 1024;
	localparam int ROW_CAP    = 16;
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int SLOT_W     = $clog2(ROW_CAP);
	localparam int CNT_W      = SLOT_W + 1;
	localparam int ENTRY_AW   = ROW_W + SLOT_W;
	localparam int COL_W      = 16;
	localparam int VAL_W      = 32;
	localparam int TOT_W      = 15;
	localparam int NROWS_W    = 11;
	localparam int NCOLS_W    = 17;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 17;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_SET  = 2'd0;
	localparam mode_t MODE_READ = 2'd1;
	localparam mode_t MODE_FIX  = 2'd2;
	localparam mode_t MODE_NOP  = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_ROW  = 2'd1;
	localparam status_t ST_COL  = 2'd2;
	localparam status_t ST_FULL = 2'd3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_NUM_ROWS = 1'd0;
	localparam cfg_idx_t CFG_NUM_COLS = 1'd1;

endpackage

// ===== sv/srat_ram.sv =====
module srat_ram #(
	parameter int ADDR_W = 4,
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/sparse_row_assembly_table_core.sv =====
// Sparse row table: one transaction per command, each ending with a done strobe.
// The single column compare port scans the row one slot per cycle (up to 16 slots);
// a diagonal swap adds value reads and writes.
// Throughput: one command at a time; busy drops the cycle after the done strobe.
// Reset: async, active low; then a sweep clears all 1024 row counts with busy high.
// The receiver cannot stall: each result is registered and held until the next command finishes.
`include "sparse_row_assembly_table_core_defines.svh"

module sparse_row_assembly_table_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// command channel
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       mode,
	input  logic [srat_pkg::ROW_W-1:0]       row,
	input  logic [srat_pkg::COL_W-1:0]       column,
	input  logic [srat_pkg::VAL_W-1:0]       value,
	// result channel
	output logic                             done,
	output logic [1:0]                       status,
	output logic [srat_pkg::VAL_W-1:0]       read_value,
	output logic                             found,
	output logic [srat_pkg::CNT_W-1:0]       entries_in_row,
	output logic [srat_pkg::TOT_W-1:0]       total_entries,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [srat_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [srat_pkg::CFG_DATA_W-1:0]  cfg_data
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_CNT, S_SRCH, S_RDK, S_RDKW, S_RD0, S_RD0W,
		S_WRX, S_WRS, S_FIN, S_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [srat_pkg::NROWS_W-1:0]  nrows_q;
	logic [srat_pkg::NCOLS_W-1:0]  ncols_q;

	// command context
	srat_pkg::mode_t               mode_q;
	logic [srat_pkg::ROW_W-1:0]    row_q;
	logic [srat_pkg::COL_W-1:0]    key_q;   // column searched: row for fix diagonal
	logic [srat_pkg::VAL_W-1:0]    val_q;
	logic [srat_pkg::CNT_W-1:0]    n_q;     // entries in the row before this command
	logic                          rowok_q;

	// search unit
	logic [srat_pkg::CNT_W-1:0]    ik_q;    // next slot to issue
	logic                          cv_q;    // compare slot valid
	logic [srat_pkg::SLOT_W-1:0]   ck_q;    // slot being compared
	logic [srat_pkg::COL_W-1:0]    col0_q;  // column of slot 0, seen during search

	// update plan
	logic                          swap_q;  // move slot 0 to slot xs_q
	logic                          app_q;   // entry appended
	logic [srat_pkg::SLOT_W-1:0]   xs_q;
	logic [srat_pkg::SLOT_W-1:0]   ws_q;
	logic [srat_pkg::VAL_W-1:0]    wval_q;
	logic [srat_pkg::VAL_W-1:0]    v0_q;

	// result
	srat_pkg::status_t             st_q;
	logic                          fnd_q;
	logic [srat_pkg::VAL_W-1:0]    rval_q;
	logic [srat_pkg::TOT_W-1:0]    total_q;
	logic [srat_pkg::ROW_W-1:0]    clr_q;

	logic [srat_pkg::TOT_W-1:0]    total_out_q;
	logic [srat_pkg::CNT_W-1:0]    cnt_out_q;
	srat_pkg::status_t             st_out_q;
	logic                          fnd_out_q;
	logic [srat_pkg::VAL_W-1:0]    rval_out_q;

	// memory ports
	logic                          ent_we;
	logic [srat_pkg::ENTRY_AW-1:0] ent_waddr;
	logic [srat_pkg::COL_W-1:0]    col_wdata;
	logic [srat_pkg::VAL_W-1:0]    val_wdata;
	logic [srat_pkg::ENTRY_AW-1:0] col_raddr;
	logic [srat_pkg::ENTRY_AW-1:0] val_raddr;
	logic [srat_pkg::COL_W-1:0]    col_rd;
	logic [srat_pkg::VAL_W-1:0]    val_rd;
	logic                          rc_we;
	logic [srat_pkg::ROW_W-1:0]    rc_waddr;
	logic [srat_pkg::CNT_W-1:0]    rc_wdata;
	logic [srat_pkg::CNT_W-1:0]    rc_rd;

	// decisions
	logic                          accept;
	logic [srat_pkg::CNT_W-1:0]    n_cur;
	logic                          key_ok;
	logic                          is_diag;
	logic                          hit_now;
	logic                          last_cmp;
	logic                          miss_now;

	assign accept   = start && (state_q == S_IDLE);
	assign n_cur    = (state_q == S_CNT) ? rc_rd : n_q;
	assign key_ok   = {1'b0, key_q} < ncols_q;
	assign is_diag  = key_q == srat_pkg::COL_W'(row_q);
	// The shared comparator: one stored column against the key each cycle.
	assign hit_now  = (state_q == S_SRCH) && cv_q && (col_rd == key_q);
	assign last_cmp = (srat_pkg::CNT_W'(ck_q) + srat_pkg::CNT_W'(1)) == n_q;
	assign miss_now = ((state_q == S_SRCH) && cv_q && !hit_now && last_cmp)
		|| ((state_q == S_CNT) && (mode_q != srat_pkg::MODE_NOP) && key_ok
			&& (rc_rd == '0));

	// Entry memories share one write port; WRX stores the displaced slot 0,
	// WRS stores the key entry.
	assign ent_we    = (state_q == S_WRX) || (state_q == S_WRS);
	assign ent_waddr = (state_q == S_WRX) ? {row_q, xs_q} : {row_q, ws_q};
	assign col_wdata = (state_q == S_WRX) ? col0_q : key_q;
	assign val_wdata = (state_q == S_WRX) ? v0_q : wval_q;
	assign col_raddr = {row_q, ik_q[srat_pkg::SLOT_W-1:0]};
	assign val_raddr = (state_q == S_RD0) ? {row_q, srat_pkg::SLOT_W'(0)} : {row_q, xs_q};

	// Row counts: cleared by the reset sweep, bumped on append.
	assign rc_we    = (state_q == S_CLR) || ((state_q == S_FIN) && app_q);
	assign rc_waddr = (state_q == S_CLR) ? clr_q : row_q;
	assign rc_wdata = (state_q == S_CLR) ? '0 : n_q + srat_pkg::CNT_W'(1);

	srat_ram #(.ADDR_W(srat_pkg::ENTRY_AW), .DATA_W(srat_pkg::COL_W)) u_col_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (col_wdata),
		.raddr (col_raddr),
		.rdata (col_rd)
	);

	srat_ram #(.ADDR_W(srat_pkg::ENTRY_AW), .DATA_W(srat_pkg::VAL_W)) u_val_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (val_wdata),
		.raddr (val_raddr),
		.rdata (val_rd)
	);

	// The row count is read at the command's row in the accept cycle.
	srat_ram #(.ADDR_W(srat_pkg::ROW_W), .DATA_W(srat_pkg::CNT_W)) u_rcnt_ram (
		.clk   (clk),
		.we    (rc_we),
		.waddr (rc_waddr),
		.wdata (rc_wdata),
		.raddr (row),
		.rdata (rc_rd)
	);

	// Configuration: always ready, taken in any state.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrows_q <= '0;
			ncols_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				srat_pkg::CFG_NUM_ROWS: nrows_q <= cfg_data[srat_pkg::NROWS_W-1:0];
				srat_pkg::CFG_NUM_COLS: ncols_q <= cfg_data[srat_pkg::NCOLS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			mode_q      <= srat_pkg::MODE_NOP;
			row_q       <= '0;
			key_q       <= '0;
			val_q       <= '0;
			n_q         <= '0;
			rowok_q     <= 1'b0;
			ik_q        <= '0;
			cv_q        <= 1'b0;
			ck_q        <= '0;
			col0_q      <= '0;
			swap_q      <= 1'b0;
			app_q       <= 1'b0;
			xs_q        <= '0;
			ws_q        <= '0;
			wval_q      <= '0;
			v0_q        <= '0;
			st_q        <= srat_pkg::ST_OK;
			fnd_q       <= 1'b0;
			rval_q      <= '0;
			total_q     <= '0;
			total_out_q <= '0;
			cnt_out_q   <= '0;
			st_out_q    <= srat_pkg::ST_OK;
			fnd_out_q   <= 1'b0;
			rval_out_q  <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					// sweep every row count to zero before the first command
					clr_q <= clr_q + srat_pkg::ROW_W'(1);
					if (clr_q == srat_pkg::ROW_W'(srat_pkg::MAX_ROWS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						mode_q  <= mode;
						row_q   <= row;
						key_q   <= (mode == srat_pkg::MODE_FIX) ?
							srat_pkg::COL_W'(row) : column;
						val_q   <= value;
						n_q     <= '0;
						rowok_q <= srat_pkg::NROWS_W'(row) < nrows_q;
						swap_q  <= 1'b0;
						app_q   <= 1'b0;
						fnd_q   <= 1'b0;
						rval_q  <= '0;
						if (srat_pkg::NROWS_W'(row) < nrows_q) begin
							st_q    <= srat_pkg::ST_OK;
							state_q <= S_CNT;
						end else begin
							// bad row: report without touching the table
							st_q    <= (mode == srat_pkg::MODE_NOP) ?
								srat_pkg::ST_OK : srat_pkg::ST_ROW;
							state_q <= S_FIN;
						end
					end
				end
				S_CNT: begin
					n_q  <= rc_rd;
					ik_q <= '0;
					cv_q <= 1'b0;
					if (mode_q == srat_pkg::MODE_NOP) begin
						state_q <= S_FIN;
					end else if (!key_ok) begin
						st_q    <= srat_pkg::ST_COL;
						state_q <= S_FIN;
					end else if (rc_rd != '0) begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					// issue one slot per cycle; compare it the cycle after
					cv_q <= ik_q < n_q;
					ck_q <= ik_q[srat_pkg::SLOT_W-1:0];
					if (ik_q < n_q) begin
						ik_q <= ik_q + srat_pkg::CNT_W'(1);
					end
					if (cv_q && (ck_q == '0)) begin
						col0_q <= col_rd;
					end
				end
				S_RDK: state_q <= S_RDKW;
				S_RDKW: begin
					rval_q  <= (mode_q == srat_pkg::MODE_READ) ? val_rd : '0;
					wval_q  <= val_rd;
					state_q <= swap_q ? S_RD0 : S_FIN;
				end
				S_RD0: state_q <= S_RD0W;
				S_RD0W: begin
					v0_q    <= val_rd;
					state_q <= S_WRX;
				end
				S_WRX: state_q <= S_WRS;
				S_WRS: state_q <= S_FIN;
				S_FIN: begin
					total_q     <= total_q + srat_pkg::TOT_W'(app_q);
					total_out_q <= total_q + srat_pkg::TOT_W'(app_q);
					cnt_out_q   <= rowok_q ? n_q + srat_pkg::CNT_W'(app_q) : '0;
					st_out_q    <= st_q;
					fnd_out_q   <= fnd_q;
					rval_out_q  <= rval_q;
					state_q     <= S_DONE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase

			// Search outcome: plan the writes and the swap, override the next state.
			if (miss_now) begin
				if (mode_q == srat_pkg::MODE_READ) begin
					state_q <= S_FIN;
				end else if (n_cur == srat_pkg::CNT_W'(srat_pkg::ROW_CAP)) begin
					st_q    <= srat_pkg::ST_FULL;
					state_q <= S_FIN;
				end else begin
					app_q  <= 1'b1;
					wval_q <= (mode_q == srat_pkg::MODE_SET) ? val_q : '0;
					if (is_diag && (n_cur != '0)) begin
						// new diagonal goes to slot 0, old slot 0 to the tail
						swap_q  <= 1'b1;
						xs_q    <= n_cur[srat_pkg::SLOT_W-1:0];
						ws_q    <= '0;
						state_q <= S_RD0;
					end else begin
						ws_q    <= n_cur[srat_pkg::SLOT_W-1:0];
						state_q <= S_WRS;
					end
				end
			end else if (hit_now) begin
				fnd_q <= 1'b1;
				xs_q  <= ck_q;
				unique case (mode_q)
					srat_pkg::MODE_SET: begin
						ws_q    <= ck_q;
						wval_q  <= val_q;
						state_q <= S_WRS;
					end
					srat_pkg::MODE_READ: state_q <= S_RDK;
					srat_pkg::MODE_FIX: begin
						if (ck_q == '0) begin
							state_q <= S_FIN;
						end else begin
							swap_q  <= 1'b1;
							ws_q    <= '0;
							state_q <= S_RDK;
						end
					end
					default: state_q <= S_FIN;
				endcase
			end
		end
	end

	assign busy           = state_q != S_IDLE;
	assign done           = state_q == S_DONE;
	assign status         = st_out_q;
	assign read_value     = rval_out_q;
	assign found          = fnd_out_q;
	assign entries_in_row = cnt_out_q;
	assign total_entries  = total_out_q;

	`SRAT_ASSERT_IMP(a_cnt_cap, done, entries_in_row <= srat_pkg::CNT_W'(srat_pkg::ROW_CAP))
	`SRAT_ASSERT_IMP(a_found_ok, done && found, status == srat_pkg::ST_OK)
	`SRAT_ASSERT_IMP(a_cmp_bound, (state_q == S_SRCH) && cv_q, srat_pkg::CNT_W'(ck_q) < n_q)
	`SRAT_ASSERT_NXT(a_total_step, state_q == S_FIN, total_q == $past(total_q) + srat_pkg::TOT_W'($past(app_q)))
	`SRAT_ASSERT_NXT(a_busy_after_start, start && !busy, busy)

endmodule
